[sv/assert_macros.svh]
// Assertion macros used by the checker file.
// Needs a clk and an arst_n signal in the scope where a macro is used.
`ifndef ASSERT_MACROS_SVH
`define ASSERT_MACROS_SVH

// Clocked property, switched off while reset is asserted.
`define ASSERT_CLK(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) disable iff (!arst_n) prop) else $error(msg);

// Clocked property that is checked during reset too.
`define ASSERT_ALWAYS(lbl, prop, msg) \
	lbl: assert property (@(posedge clk) prop) else $error(msg);

`endif

[sv/wsip_pkg.sv]
// Types and constants of the wide string to integer parser.
// No dependencies; imported by every module of the block.
package wsip_pkg;

	localparam int CHAR_W   = 16;
	localparam int RADIX_W  = 6;
	localparam int VALUE_W  = 32;
	localparam int OFFSET_W = 12;
	localparam int STATUS_W = 2;

	localparam logic [RADIX_W-1:0] RADIX_RESET = 6'd10;
	localparam logic [RADIX_W-1:0] MAX_RADIX   = 6'd36;
	localparam logic [RADIX_W-1:0] HEX_RADIX   = 6'd16;
	localparam logic [RADIX_W-1:0] DEC_RADIX   = 6'd10;
	localparam logic [RADIX_W-1:0] OCT_RADIX   = 6'd8;
	localparam logic [RADIX_W-1:0] BAD_RADIX   = 6'd1;
	localparam logic [RADIX_W-1:0] MIN_RADIX   = 6'd2;

	localparam logic [CHAR_W-1:0] CH_TAB     = 16'h0009;
	localparam logic [CHAR_W-1:0] CH_CR      = 16'h000D;
	localparam logic [CHAR_W-1:0] CH_SPACE   = 16'h0020;
	localparam logic [CHAR_W-1:0] CH_PLUS    = 16'h002B;
	localparam logic [CHAR_W-1:0] CH_MINUS   = 16'h002D;
	localparam logic [CHAR_W-1:0] CH_ZERO    = 16'h0030;
	localparam logic [CHAR_W-1:0] CH_NINE    = 16'h0039;
	localparam logic [CHAR_W-1:0] CH_UPPER_A = 16'h0041;
	localparam logic [CHAR_W-1:0] CH_UPPER_X = 16'h0058;
	localparam logic [CHAR_W-1:0] CH_LOWER_X = 16'h0078;
	localparam logic [CHAR_W-1:0] CASE_BIT   = 16'h0020;
	localparam logic [CHAR_W-1:0] LETTERS    = 16'd26;
	localparam logic [RADIX_W-1:0] LETTER_BASE = 6'd10;

	localparam logic [STATUS_W-1:0] ST_OK    = 2'd0;
	localparam logic [STATUS_W-1:0] ST_RANGE = 2'd1;
	localparam logic [STATUS_W-1:0] ST_BASE  = 2'd2;

	typedef enum logic [4:0] {
		PH_IDLE   = 5'b00001,
		PH_LEAD   = 5'b00010,
		PH_SIGNED = 5'b00100,
		PH_ZERO   = 5'b01000,
		PH_DIGITS = 5'b10000
	} phase_t;

	typedef struct packed {
		logic [CHAR_W-1:0] char_code;
		logic              string_start;
	} in_t;

	typedef struct packed {
		logic signed [VALUE_W-1:0] value;
		logic [OFFSET_W-1:0]       end_offset;
		logic [STATUS_W-1:0]       status;
	} out_t;

	typedef struct packed {
		logic               is_ws;
		logic               is_plus;
		logic               is_minus;
		logic               is_zero;
		logic               is_x;
		logic               is_dig;
		logic [RADIX_W-1:0] digit;
	} chr_class_t;

endpackage

[sv/wide_string_to_integer_parser_core.sv]
// Top level of the streaming wide string to integer parser (strtol rules).
// Depends on wsip_pkg, wsip_in_stage, wsip_char_class and wsip_parse_core.
//
//   channel   signals                       payload
//   in        in_valid / in_ready           in_item  (in_t: char_code, string_start)
//   out       out_valid / out_ready         out_item (out_t: value, end_offset, status)
//   config    radix_we                      radix_wdata (6 bits)
//
// One character per cycle unless the output stalls; input register, then result register.
// The rate is set by the single step unit: one multiply-add and limit compare per char.
// arst_n clears the parse state and both valid flags; radix resets to 10.
// A result held in the output register stalls the step stage, while the input
// register still takes one more character.
module wide_string_to_integer_parser_core import wsip_pkg::*; #(
	parameter int VALUE_BITS = 32,
	parameter int MAX_CHARS  = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               radix_we,
	input  logic [RADIX_W-1:0] radix_wdata,
	input  logic               in_valid,
	output logic               in_ready,
	input  in_t                in_item,
	output logic               out_valid,
	input  logic               out_ready,
	output out_t               out_item
);

	logic       take;
	logic       valid_s1;
	in_t        item_s1;
	chr_class_t cls;

	wsip_in_stage u_in (
		.clk      (clk),
		.arst_n   (arst_n),
		.in_valid (in_valid),
		.in_ready (in_ready),
		.in_item  (in_item),
		.take     (take),
		.valid_s1 (valid_s1),
		.item_s1  (item_s1)
	);

	wsip_char_class u_cls (
		.char_code (item_s1.char_code),
		.cls       (cls)
	);

	wsip_parse_core #(
		.VALUE_BITS (VALUE_BITS),
		.MAX_CHARS  (MAX_CHARS)
	) u_core (
		.clk         (clk),
		.arst_n      (arst_n),
		.radix_we    (radix_we),
		.radix_wdata (radix_wdata),
		.valid_s1    (valid_s1),
		.item_s1     (item_s1),
		.cls         (cls),
		.take        (take),
		.out_valid   (out_valid),
		.out_ready   (out_ready),
		.out_item    (out_item)
	);

endmodule

[sv/wsip_in_stage.sv]
// Input register stage of the parser: holds one character until the core takes it.
// Depends on wsip_pkg.
module wsip_in_stage import wsip_pkg::*; (
	input  logic clk,
	input  logic arst_n,
	input  logic in_valid,
	output logic in_ready,
	input  in_t  in_item,
	input  logic take,
	output logic valid_s1,
	output in_t  item_s1
);

	assign in_ready = !valid_s1 || take;

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			valid_s1 <= 1'b0;
		end else if (in_ready) begin
			valid_s1 <= in_valid;
		end
	end

	always_ff @(posedge clk) begin
		if (in_ready && in_valid) begin
			item_s1 <= in_item;
		end
	end

endmodule

[sv/wsip_char_class.sv]
// Character classifier: whitespace, sign, zero, hex prefix and digit value.
// Depends on wsip_pkg.
module wsip_char_class import wsip_pkg::*; (
	input  logic [CHAR_W-1:0] char_code,
	output chr_class_t        cls
);

	logic [CHAR_W-1:0] letter_off;

	// Folding the case bit maps 'a'..'z' onto 'A'..'Z'.
	assign letter_off = (char_code - CH_UPPER_A) & ~CASE_BIT;

	always_comb begin
		cls.is_ws    = (char_code == CH_SPACE) ||
			(char_code >= CH_TAB && char_code <= CH_CR);
		cls.is_plus  = (char_code == CH_PLUS);
		cls.is_minus = (char_code == CH_MINUS);
		cls.is_zero  = (char_code == CH_ZERO);
		cls.is_x     = (char_code == CH_LOWER_X) || (char_code == CH_UPPER_X);
		cls.is_dig   = 1'b0;
		cls.digit    = '0;
		if (char_code >= CH_ZERO && char_code <= CH_NINE) begin
			cls.is_dig = 1'b1;
			cls.digit  = RADIX_W'(char_code - CH_ZERO);
		end else if (char_code >= CH_UPPER_A && letter_off < LETTERS) begin
			cls.is_dig = 1'b1;
			cls.digit  = RADIX_W'(letter_off) + LETTER_BASE;
		end
	end

endmodule

[sv/wsip_parse_core.sv]
// Parse state, one-character step logic and result register of the parser.
// Depends on wsip_pkg; fed by wsip_in_stage and wsip_char_class.
module wsip_parse_core import wsip_pkg::*; #(
	parameter int VALUE_BITS = 32,
	parameter int MAX_CHARS  = 4096
) (
	input  logic               clk,
	input  logic               arst_n,
	input  logic               radix_we,
	input  logic [RADIX_W-1:0] radix_wdata,
	input  logic               valid_s1,
	input  in_t                item_s1,
	input  chr_class_t         cls,
	output logic               take,
	output logic               out_valid,
	input  logic               out_ready,
	output out_t               out_item
);

	localparam int POS_W  = $clog2(MAX_CHARS);
	localparam int PROD_W = VALUE_BITS + RADIX_W;
	localparam logic [POS_W-1:0] POS_MAX = POS_W'(MAX_CHARS - 1);
	localparam logic [VALUE_BITS-1:0] MAXV = {1'b0, {(VALUE_BITS-1){1'b1}}};

	logic [RADIX_W-1:0]    radix_q;
	phase_t                phase_q, ph_c, ph_n;
	logic [VALUE_BITS-1:0] mag_q, mag_n;
	logic                  neg_q, neg_n;
	logic                  ovf_q, ovf_n;
	logic [RADIX_W-1:0]    base_q, base_n;
	logic [POS_W-1:0]      pos_q, pos_c, pos_inc, pos_n;
	logic [POS_W-1:0]      endp_q, endp_n;
	logic                  emit;
	logic [VALUE_BITS-1:0] res_v, limit;
	logic [STATUS_W-1:0]   res_st;
	logic                  do_signed, do_digit;
	logic [PROD_W-1:0]     prod;

	// A character moves on only when a result it may produce has a free slot.
	assign take = valid_s1 && (!out_valid || out_ready);

	always_comb begin
		ph_n      = phase_q;
		mag_n     = mag_q;
		neg_n     = neg_q;
		ovf_n     = ovf_q;
		base_n    = base_q;
		endp_n    = endp_q;
		pos_c     = pos_q;
		emit      = 1'b0;
		res_v     = '0;
		res_st    = ST_OK;
		do_signed = 1'b0;
		do_digit  = 1'b0;
		prod      = '0;
		limit     = MAXV;

		if (item_s1.string_start) begin
			mag_n  = '0;
			neg_n  = 1'b0;
			ovf_n  = 1'b0;
			pos_c  = '0;
			endp_n = '0;
			base_n = radix_q;
			ph_n   = PH_LEAD;
			if (radix_q == BAD_RADIX || radix_q > MAX_RADIX) begin
				ph_n   = PH_IDLE;
				emit   = 1'b1;
				res_st = ST_BASE;
			end
		end
		ph_c    = ph_n;
		pos_inc = (pos_c < POS_MAX) ? pos_c + 1'b1 : pos_c;
		pos_n   = pos_c;

		unique case (ph_c)
			PH_LEAD: begin
				if (cls.is_ws) begin
					pos_n = pos_inc;
				end else if (cls.is_plus || cls.is_minus) begin
					neg_n = cls.is_minus;
					pos_n = pos_inc;
					ph_n  = PH_SIGNED;
				end else begin
					do_signed = 1'b1;
				end
			end
			PH_SIGNED: do_signed = 1'b1;
			PH_ZERO: begin
				ph_n = PH_DIGITS;
				if ((base_n == HEX_RADIX || base_n == '0) && cls.is_x) begin
					base_n = HEX_RADIX;
					pos_n  = pos_inc;
				end else begin
					if (base_n == '0) begin
						base_n = OCT_RADIX;
					end
					do_digit = 1'b1;
				end
			end
			PH_DIGITS: do_digit = 1'b1;
			PH_IDLE: ;
			default: ;
		endcase

		if (do_signed) begin
			if (cls.is_zero) begin
				pos_n  = pos_inc;
				endp_n = pos_inc;
				ph_n   = PH_ZERO;
			end else begin
				if (base_n == '0) begin
					base_n = DEC_RADIX;
				end
				ph_n     = PH_DIGITS;
				do_digit = 1'b1;
			end
		end

		if (do_digit) begin
			limit = neg_n ? MAXV + 1'b1 : MAXV;
			if (!cls.is_dig || cls.digit >= base_n || base_n < MIN_RADIX) begin
				// Number ends here; overflow saturates to the signed limit.
				res_v  = ovf_n ? limit : mag_n;
				if (neg_n) begin
					res_v = '0 - res_v;
				end
				res_st = ovf_n ? ST_RANGE : ST_OK;
				emit   = 1'b1;
				ph_n   = PH_IDLE;
			end else begin
				pos_n  = pos_inc;
				endp_n = pos_inc;
				if (!ovf_n) begin
					prod = PROD_W'(mag_n) * PROD_W'(base_n) + PROD_W'(cls.digit);
					if (prod > PROD_W'(limit)) begin
						ovf_n = 1'b1;
					end else begin
						mag_n = prod[VALUE_BITS-1:0];
					end
				end
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			radix_q <= RADIX_RESET;
			phase_q <= PH_IDLE;
			mag_q   <= '0;
			neg_q   <= 1'b0;
			ovf_q   <= 1'b0;
			base_q  <= '0;
			pos_q   <= '0;
			endp_q  <= '0;
		end else begin
			if (radix_we) begin
				radix_q <= radix_wdata;
			end
			if (take) begin
				phase_q <= ph_n;
				mag_q   <= mag_n;
				neg_q   <= neg_n;
				ovf_q   <= ovf_n;
				base_q  <= base_n;
				pos_q   <= pos_n;
				endp_q  <= endp_n;
			end
		end
	end

	always_ff @(posedge clk or negedge arst_n) begin
		if (!arst_n) begin
			out_valid <= 1'b0;
		end else if (take && emit) begin
			out_valid <= 1'b1;
		end else if (out_ready) begin
			out_valid <= 1'b0;
		end
	end

	always_ff @(posedge clk) begin
		if (take && emit) begin
			out_item.value      <= VALUE_W'(signed'(res_v));
			out_item.end_offset <= OFFSET_W'(endp_n);
			out_item.status     <= res_st;
		end
	end

endmodule

[sv/wsip_checker.sv]
// Port-level checks of the parser, bound to the top level.
// Depends on wsip_pkg and assert_macros.svh.
`include "assert_macros.svh"

module wsip_checker import wsip_pkg::*; (
	input logic clk,
	input logic arst_n,
	input logic out_valid,
	input logic out_ready,
	input out_t out_item
);

	// A stalled result holds still.
	`ASSERT_CLK(a_out_hold, out_valid && !out_ready |=> out_valid && $stable(out_item), "result changed while stalled")
	`ASSERT_CLK(a_status_code, out_valid |-> (out_item.status == ST_OK || out_item.status == ST_RANGE || out_item.status == ST_BASE), "unknown status code")
	// A bad base reports zero value and no characters consumed.
	`ASSERT_CLK(a_bad_base, out_valid && out_item.status == ST_BASE |-> out_item.value == '0 && out_item.end_offset == '0, "bad base result not zero")
	`ASSERT_ALWAYS(a_reset_quiet, !arst_n |-> !out_valid, "result valid during reset")

endmodule

bind wide_string_to_integer_parser_core wsip_checker u_wsip_checker (
	.clk       (clk),
	.arst_n    (arst_n),
	.out_valid (out_valid),
	.out_ready (out_ready),
	.out_item  (out_item)
);

[tb/sv/tb_wide_string_to_integer_parser_core.sv]
// Self-checking bench for wide_string_to_integer_parser_core: streams wide-char strings
// under several radix settings and checks every value, end offset and status.
// Depends on wsip_pkg and the parser RTL; the expected numbers come from a scoreboard class.
module tb_wide_string_to_integer_parser_core;
	import wsip_pkg::*;

	localparam int VALUE_BITS   = 32;
	localparam int MAX_CHARS    = 4096;
	localparam int CLK_PERIOD   = 4;
	localparam int RUN_LIMIT    = 4_000_000;
	localparam int SETTLE       = 6;
	localparam int HOLD_CYCLES  = 60;
	localparam int ITEM_TARGET  = 1650;
	localparam int PHASE_ITEMS  = 130;
	localparam int QUIET_ITEMS  = 200;
	localparam int LONG_LEN     = 40;
	localparam int unsigned NO_DIGIT = 99;

	localparam logic [RADIX_W-1:0] AUTO_RADIX = 6'd0;
	localparam logic [CHAR_W-1:0]  CH_NUL     = 16'h0000;
	localparam logic [CHAR_W-1:0]  CH_TOP     = 16'hFFFF;
	localparam logic [63:0]        VALUE_MAX  = (64'd1 << (VALUE_BITS - 1)) - 64'd1;

	class number_scoreboard;
		logic [RADIX_W-1:0] radix_q;
		out_t               pending_numbers[$];
		int                 mismatches;
		phase_t             phase;
		logic [63:0]        mag;
		bit                 neg;
		bit                 ovf;
		logic [RADIX_W-1:0] base;
		int unsigned        pos;
		int unsigned        end_pos;

		function new();
			radix_q    = RADIX_RESET;
			phase      = PH_IDLE;
			mag        = '0;
			neg        = 1'b0;
			ovf        = 1'b0;
			base       = '0;
			pos        = 0;
			end_pos    = 0;
			mismatches = 0;
		endfunction

		function int unsigned digit_value(logic [CHAR_W-1:0] ch);
			logic [CHAR_W-1:0] t;
			if (ch >= CH_ZERO && ch <= CH_NINE)
				return int'(ch - CH_ZERO);
			if (ch >= CH_UPPER_A) begin
				// folding the case bit maps both letter ranges onto 0..25
				t = (ch - CH_UPPER_A) & ~CASE_BIT;
				if (t < LETTERS)
					return int'(t) + int'(LETTER_BASE);
			end
			return NO_DIGIT;
		endfunction

		function void step_position();
			if (pos < MAX_CHARS - 1)
				pos++;
		endfunction

		function void add_number(logic [63:0] v, logic [STATUS_W-1:0] st);
			out_t e;
			e.value      = v[VALUE_W-1:0];
			e.end_offset = OFFSET_W'(end_pos);
			e.status     = st;
			pending_numbers.push_back(e);
		endfunction

		function void take_digit(logic [CHAR_W-1:0] ch);
			int unsigned d;
			logic [63:0] limit;
			logic [63:0] v;
			d = digit_value(ch);
			limit = neg ? VALUE_MAX + 64'd1 : VALUE_MAX;
			if (d >= base || base < MIN_RADIX) begin
				v = ovf ? limit : mag;
				if (neg)
					v = -v;
				add_number(v, ovf ? ST_RANGE : ST_OK);
				phase = PH_IDLE;
				return;
			end
			step_position();
			end_pos = pos;
			// once saturated, digits still move the end offset but not the value
			if (!ovf) begin
				if (mag > limit / base || (mag == limit / base && d > limit % base))
					ovf = 1'b1;
				else
					mag = mag * base + d;
			end
		endfunction

		function void take_char(in_t item);
			logic [CHAR_W-1:0] ch;
			ch = item.char_code;
			if (item.string_start) begin
				mag     = '0;
				neg     = 1'b0;
				ovf     = 1'b0;
				pos     = 0;
				end_pos = 0;
				base    = radix_q;
				if (base == BAD_RADIX || base > MAX_RADIX) begin
					phase = PH_IDLE;
					add_number('0, ST_BASE);
					return;
				end
				phase = PH_LEAD;
			end
			if (phase == PH_LEAD) begin
				if (ch == CH_SPACE || (ch >= CH_TAB && ch <= CH_CR)) begin
					step_position();
					return;
				end
				if (ch == CH_PLUS || ch == CH_MINUS) begin
					neg = (ch == CH_MINUS);
					step_position();
					phase = PH_SIGNED;
					return;
				end
				phase = PH_SIGNED;
			end
			case (phase)
				PH_SIGNED: begin
					if (ch == CH_ZERO) begin
						step_position();
						end_pos = pos;
						phase = PH_ZERO;
					end else begin
						if (base == AUTO_RADIX)
							base = DEC_RADIX;
						phase = PH_DIGITS;
						take_digit(ch);
					end
				end
				PH_ZERO: begin
					phase = PH_DIGITS;
					if ((base == HEX_RADIX || base == AUTO_RADIX) &&
							(ch == CH_LOWER_X || ch == CH_UPPER_X)) begin
						base = HEX_RADIX;
						step_position();
					end else begin
						if (base == AUTO_RADIX)
							base = OCT_RADIX;
						take_digit(ch);
					end
				end
				PH_DIGITS: take_digit(ch);
				default: ;
			endcase
		endfunction

		task report_mismatch(string msg);
			$display("%0t mismatch: %s", $realtime, msg);
			mismatches++;
		endtask

		task check_number(out_t got);
			out_t want;
			if (pending_numbers.size() == 0) begin
				report_mismatch($sformatf("result with none pending: value %0d offset %0d status %0d",
					got.value, got.end_offset, got.status));
				return;
			end
			want = pending_numbers.pop_front();
			if (got.value !== want.value)
				report_mismatch($sformatf("value %0d, want %0d", got.value, want.value));
			if (got.end_offset !== want.end_offset)
				report_mismatch($sformatf("end_offset %0d, want %0d", got.end_offset,
					want.end_offset));
			if (got.status !== want.status)
				report_mismatch($sformatf("status %0d, want %0d", got.status, want.status));
		endtask
	endclass

	logic               clk         = 1'b0;
	logic               arst_n;
	logic               radix_we    = 1'b0;
	logic [RADIX_W-1:0] radix_wdata = '0;
	logic               in_valid    = 1'b0;
	logic               in_ready;
	in_t                in_item     = '0;
	logic               out_valid;
	logic               out_ready   = 1'b0;
	out_t               out_item;

	number_scoreboard  board = new();
	logic [CHAR_W-1:0] text_q[$];
	int                chars_counted = 0;
	bit                tx_gaps       = 1'b0;
	bit                rx_stalls     = 1'b0;
	bit                hold_off_req  = 1'b0;
	int unsigned       radix_plan[$] = '{AUTO_RADIX, HEX_RADIX, MIN_RADIX, MAX_RADIX, OCT_RADIX,
		BAD_RADIX, DEC_RADIX, 37, 3, 63, 35, AUTO_RADIX, HEX_RADIX};

	wide_string_to_integer_parser_core #(
		.VALUE_BITS(VALUE_BITS),
		.MAX_CHARS (MAX_CHARS)
	) i_dut (
		.clk        (clk),
		.arst_n     (arst_n),
		.radix_we   (radix_we),
		.radix_wdata(radix_wdata),
		.in_valid   (in_valid),
		.in_ready   (in_ready),
		.in_item    (in_item),
		.out_valid  (out_valid),
		.out_ready  (out_ready),
		.out_item   (out_item)
	);

	always #(CLK_PERIOD / 2) clk = ~clk;

	// output side first: a result never belongs to a char transferred at the same edge
	always @(posedge clk) begin
		if (arst_n && out_valid && out_ready)
			board.check_number(out_item);
		if (arst_n && in_valid && in_ready)
			board.take_char(in_item);
	end

	function automatic logic [CHAR_W-1:0] wc(byte unsigned c);
		return {8'h00, c};
	endfunction

	function automatic logic [CHAR_W-1:0] digit_char(int unsigned d);
		if (d < LETTER_BASE)
			return CH_ZERO + CHAR_W'(d);
		return CHAR_W'(d - LETTER_BASE) +
			(($urandom_range(0, 1) == 0) ? CH_UPPER_A : (CH_UPPER_A | CASE_BIT));
	endfunction

	task automatic send_char(input in_t item);
		if (tx_gaps && $urandom_range(0, 5) == 0) begin
			in_valid <= 1'b0;
			repeat ($urandom_range(1, 6)) @(negedge clk);
		end
		in_item  <= item;
		in_valid <= 1'b1;
		do @(posedge clk); while (!in_ready);
		@(negedge clk);
	endtask

	task automatic send_text(input bit with_start);
		in_t item;
		foreach (text_q[i]) begin
			item.char_code    = text_q[i];
			item.string_start = with_start && (i == 0);
			send_char(item);
		end
		if (with_start && board.radix_q != BAD_RADIX && board.radix_q <= MAX_RADIX)
			chars_counted += text_q.size();
		text_q.delete();
	endtask

	task automatic wait_drained();
		in_valid <= 1'b0;
		while (board.pending_numbers.size() != 0)
			@(negedge clk);
		// a string that ends without a result may still be in the pipe
		repeat (SETTLE) @(negedge clk);
	endtask

	task automatic write_radix(input logic [RADIX_W-1:0] r);
		wait_drained();
		radix_we    <= 1'b1;
		radix_wdata <= r;
		@(negedge clk);
		radix_we <= 1'b0;
		board.radix_q = r;
	endtask

	task automatic send_random_string();
		int unsigned kind;
		int unsigned base;
		logic [63:0] num;
		int unsigned digs[$];
		kind = $urandom_range(0, 99);
		base = board.radix_q;
		if (base == BAD_RADIX || base > MAX_RADIX)
			base = DEC_RADIX;
		repeat ($urandom_range(0, 2))
			text_q.push_back(($urandom_range(0, 5) == 0) ? CH_SPACE :
				CH_TAB + CHAR_W'($urandom_range(0, 4)));
		case ($urandom_range(0, 3))
			1: text_q.push_back(CH_PLUS);
			2: text_q.push_back(CH_MINUS);
			default: ;
		endcase
		if (board.radix_q == AUTO_RADIX) begin
			case ($urandom_range(0, 2))
				0: begin
					text_q.push_back(CH_ZERO);
					text_q.push_back(($urandom_range(0, 1) == 0) ? CH_LOWER_X : CH_UPPER_X);
					base = HEX_RADIX;
				end
				1: begin
					text_q.push_back(CH_ZERO);
					base = OCT_RADIX;
				end
				default: base = DEC_RADIX;
			endcase
		end else if (base == HEX_RADIX && $urandom_range(0, 2) == 0) begin
			text_q.push_back(CH_ZERO);
			text_q.push_back(($urandom_range(0, 1) == 0) ? CH_LOWER_X : CH_UPPER_X);
		end
		if (kind < 60) begin
			repeat ((base < 5) ? $urandom_range(1, 34) : $urandom_range(1, 11))
				text_q.push_back(digit_char($urandom_range(0, base - 1)));
		end else if (kind < 75) begin
			// magnitudes around both saturation limits
			num = 64'h8000_0000 + 64'($urandom_range(0, 4)) - 64'd2;
			do begin
				digs.push_front(32'(num % base));
				num = num / base;
			end while (num != 0);
			foreach (digs[i])
				text_q.push_back(digit_char(digs[i]));
		end else if (kind >= 85) begin
			// left open: the next start mark abandons it
			repeat ($urandom_range(1, 5))
				text_q.push_back(digit_char($urandom_range(0, base - 1)));
		end
		if (kind < 85) begin
			case ($urandom_range(0, 3))
				0: text_q.push_back(CH_NUL);
				1: text_q.push_back(CH_SPACE);
				2: text_q.push_back(CHAR_W'($urandom_range(0, 65535)));
				default: text_q.push_back(digit_char(base));
			endcase
		end
		send_text(1'b1);
	endtask

	initial begin
		wait (arst_n);
		forever begin
			@(negedge clk);
			if (hold_off_req) begin
				hold_off_req = 1'b0;
				out_ready <= 1'b0;
				repeat (HOLD_CYCLES) @(negedge clk);
				out_ready <= 1'b1;
			end else if (rx_stalls && $urandom_range(0, 5) == 0) begin
				out_ready <= 1'b0;
				repeat ($urandom_range(1, 6)) @(negedge clk);
				out_ready <= 1'b1;
			end else begin
				out_ready <= 1'b1;
			end
		end
	end

	initial begin
		#(RUN_LIMIT);
		$display("CHECK FAILED");
		$finish;
	end

	initial begin
		in_t         item;
		int unsigned new_radix;
		int          phase_end;
		int          plan_idx;

		arst_n <= 1'b0;
		repeat (5) @(negedge clk);
		arst_n <= 1'b1;
		@(negedge clk);

		// directed strings, reset radix first
		item = '{char_code: CH_TOP, string_start: 1'b0};
		send_char(item);
		text_q = '{CH_SPACE, CH_MINUS, wc("1"), wc("2"), CH_NUL};
		send_text(1'b1);
		text_q = '{wc("9")};
		send_text(1'b1);
		text_q = '{wc("3"), CH_TOP};
		send_text(1'b1);
		text_q = '{CH_PLUS, wc("z")};
		send_text(1'b1);
		write_radix(HEX_RADIX);
		text_q = '{CH_ZERO, CH_LOWER_X, wc("g")};
		send_text(1'b1);
		text_q = '{CH_MINUS, CH_ZERO, CH_UPPER_X, wc("f"), wc(":")};
		send_text(1'b1);
		write_radix(BAD_RADIX);
		text_q = '{wc("x"), wc("5")};
		send_text(1'b1);
		write_radix(AUTO_RADIX);
		text_q = '{CH_ZERO, wc("1"), wc("7"), CH_NUL};
		send_text(1'b1);
		write_radix(DEC_RADIX);

		// long runs of leading zeros and blanks
		for (int k = 0; k < 2; k++) begin
			repeat (LONG_LEN) text_q.push_back((k == 0) ? CH_ZERO : CH_SPACE);
			text_q.push_back(wc("7"));
			text_q.push_back(CH_NUL);
			send_text(1'b1);
		end

		// receiver holds off while short numbers keep coming, so input backs up
		tx_gaps = 1'b1;
		hold_off_req = 1'b1;
		repeat (24) begin
			text_q.push_back(wc("1") + CHAR_W'($urandom_range(0, 6)));
			text_q.push_back(CH_NUL);
			send_text(1'b1);
		end

		rx_stalls = 1'b1;
		chars_counted = 0;
		plan_idx = 0;
		while (chars_counted < ITEM_TARGET) begin
			if (plan_idx < radix_plan.size())
				new_radix = radix_plan[plan_idx++];
			else if ($urandom_range(0, 3) == 0)
				new_radix = $urandom_range(0, 63);
			else
				new_radix = $urandom_range(MIN_RADIX, MAX_RADIX);
			write_radix(RADIX_W'(new_radix));
			if (new_radix == BAD_RADIX || new_radix > MAX_RADIX) begin
				repeat (6) send_random_string();
			end else begin
				phase_end = chars_counted + PHASE_ITEMS;
				while (chars_counted < phase_end && chars_counted < ITEM_TARGET) begin
					if (chars_counted > ITEM_TARGET - QUIET_ITEMS) begin
						tx_gaps   = 1'b0;
						rx_stalls = 1'b0;
					end
					if ($urandom_range(0, 19) == 0) begin
						repeat ($urandom_range(1, 4)) begin
							item.char_code    = CHAR_W'($urandom_range(0, 65535));
							item.string_start = ($urandom_range(0, 9) == 0);
							send_char(item);
						end
					end else begin
						send_random_string();
					end
				end
			end
		end

		wait_drained();
		if (board.mismatches == 0 && board.pending_numbers.size() == 0)
			$display("CHECK OK");
		else
			$display("CHECK FAILED");
		$finish;
	end

endmodule

[sim.f]
+incdir+sv
sv/wsip_pkg.sv
sv/wsip_in_stage.sv
sv/wsip_char_class.sv
sv/wsip_parse_core.sv
sv/wide_string_to_integer_parser_core.sv
sv/wsip_checker.sv
tb/sv/tb_wide_string_to_integer_parser_core.sv
